[rtl/core/ljfp_pkg.sv]
// Shared types and constants for the Lennard-Jones force pipeline.
// Holds stage numbering, register and status codes, and the side-band record.
// No dependencies.
package ljfp_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_LENGTH_SCALE = 2'd0,
        CFG_ENERGY_SCALE = 2'd1,
        CFG_ELONGATION   = 2'd2
    } t_cfg_idx;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_OK   = 2'd0,
        STAT_SAT  = 2'd1,
        STAT_ZERO = 2'd2
    } t_status;

    // Output limits (magnitudes)
    localparam logic [47:0] POS_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] NEG_MAG = 48'h8000_0000_0000;

    // Quotient widths of the two divider chains
    localparam int XBITS = 38;   // ratio s/r, below 40 in Q.32
    localparam int QBITS = 48;   // force and stiffness magnitudes

    // Stage numbering
    localparam int ST_S    = 1;
    localparam int ST_XD0  = 2;
    localparam int ST_XQ   = ST_XD0 + XBITS;
    localparam int ST_SQP  = ST_XQ + 1;
    localparam int ST_X2   = ST_XQ + 2;
    localparam int ST_X3P  = ST_XQ + 3;
    localparam int ST_X3   = ST_XQ + 4;
    localparam int ST_X6P  = ST_XQ + 5;
    localparam int ST_X6   = ST_XQ + 6;
    localparam int ST_X12P = ST_XQ + 7;
    localparam int ST_X12  = ST_XQ + 8;
    localparam int ST_MUL  = ST_XQ + 9;
    localparam int ST_ABS  = ST_XQ + 10;
    localparam int ST_EPP  = ST_XQ + 11;
    localparam int ST_SUM  = ST_XQ + 12;
    localparam int ST_DIV0 = ST_XQ + 13;
    localparam int ST_Q    = ST_DIV0 + QBITS;
    localparam int ST_OUT  = ST_Q + 1;

    // Per-item side band; bit 0 energy, bit 1 force, bit 2 stiffness
    typedef struct packed {
        logic [23:0] r;
        logic [47:0] rsq;
        logic        zero;
        logic        ovr;
        logic [2:0]  neg;
        logic [2:0]  sat;
        logic [47:0] em;
    } t_side;

endpackage

[rtl/core/lennard_jones_force_pipeline.sv]
// Lennard-Jones 6-12 energy, force and stiffness pipeline (top level).
// Depends on ljfp_pkg.
//
// Accepts one Q8.16 distance per cycle unless stalled and returns energy, force
// and stiffness in signed Q32.16 with a status code. The depth is set by two
// restoring divider chains that retire one quotient bit per stage: 38 stages for
// the ratio s/r and 48 stages for the force and stiffness quotients, which run
// side by side. A stall on the output freezes every stage at once, so nothing
// is dropped or repeated. Configuration registers feed the stages directly; the
// user must write them only while the pipeline is empty; nothing enforces it.
module lennard_jones_force_pipeline
    import ljfp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [23:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [23:0]        i_distance,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [47:0] o_energy,
    output logic signed [47:0] o_force_res,
    output logic signed [47:0] o_stiffness,
    output logic [1:0]         o_status
);

    logic [23:0]        r_length_scale;
    logic [23:0]        r_energy_scale;
    logic signed [15:0] r_elongation;

    logic               en;
    logic [ST_OUT:0]    r_vld;
    t_side              r_sd [0:ST_Q];
    t_side              sd_in;
    t_side              sd_xd0, sd_abs, sd_epp, sd_div0;

    logic [16:0]  scale_a;
    logic [40:0]  r_prod;
    logic [24:0]  r_s;
    logic [29:0]  r40;
    logic         ovr_n;

    logic [23:0]  r_xrem [0:XBITS];
    logic [XBITS-1:0] r_xw [0:XBITS];

    logic [63:0]  r_sq_ll;
    logic [37:0]  r_sq_lh;
    logic [11:0]  r_sq_hh;
    logic [37:0]  r_xa, r_xb;
    logic [75:0]  sum_x2;
    logic [42:0]  r_x2;
    logic [63:0]  r_p00;
    logic [37:0]  r_p01;
    logic [42:0]  r_p10;
    logic [16:0]  r_p11;
    logic [80:0]  sum_x3;
    logic [47:0]  r_x3;
    logic [63:0]  r_q_ll;
    logic [47:0]  r_q_lh;
    logic [31:0]  r_q_hh;
    logic [95:0]  sum_g;
    logic [63:0]  r_g, r_ga, r_gb, r_gc;
    logic [63:0]  r_h_ll, r_h_lh, r_h_hh;
    logic [127:0] sum_g2;
    logic [95:0]  r_g2, r_g2c;
    logic [99:0]  r_t12;
    logic [66:0]  r_t6;
    logic [103:0] r_t156;
    logic [69:0]  r_t42;
    logic [2:0]   neg_n;
    logic [95:0]  abs_a;
    logic [99:0]  abs_b;
    logic [103:0] abs_c;
    logic [95:0]  r_a;
    logic [99:0]  r_b;
    logic [103:0] r_c;
    logic [2:0]   clamp_n;
    logic [55:0]  r_ea0, r_ea1, r_eb0, r_eb1, r_ec0, r_ec1;
    logic [37:0]  r_ea2;
    logic [45:0]  r_eb2;
    logic [53:0]  r_ec2;
    logic [103:0] sum_e;
    logic [111:0] sum_f;
    logic [120:0] sum_s;
    logic [71:0]  r_me;
    logic [95:0]  r_mf;
    logic [120:0] r_ms;
    logic [47:0]  lim_e;
    logic         sat_e;
    logic         ovf_f, ovf_s;

    logic [23:0]  r_frem [0:QBITS];
    logic [47:0]  r_fw   [0:QBITS];
    logic [47:0]  r_srem [0:QBITS];
    logic [47:0]  r_sw   [0:QBITS];

    t_side        sdq;
    logic         neg_f, sat_f, sat_s;
    logic [47:0]  lim_f, lim_s, mag_f, mag_s;
    logic signed [47:0] n_energy, n_force, n_stiff;
    logic [1:0]   n_status;
    logic signed [47:0] r_energy, r_force, r_stiff;
    logic [1:0]   r_status;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_length_scale <= 24'd65536;
            r_energy_scale <= 24'd65536;
            r_elongation   <= 16'sd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LENGTH_SCALE: r_length_scale <= i_cfg_data;
                CFG_ENERGY_SCALE: r_energy_scale <= i_cfg_data;
                CFG_ELONGATION:   r_elongation   <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // Advance all stages unless the held result is not taken
    assign en      = !(r_vld[ST_OUT] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[ST_OUT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[ST_OUT-1:0], i_valid};
        end
    end

    // Stage math ahead of the dividers and between the multipliers
    always_comb begin
        scale_a = 17'h10000 + {r_elongation[15], r_elongation};

        sd_in     = '0;
        sd_in.r   = i_distance;
        sd_in.rsq = 48'(i_distance) * 48'(i_distance);
        sd_in.zero = (i_distance == 24'd0);

        // ratio at or above 40 when s >= 40 r
        r40   = (30'(r_sd[ST_S].r) << 5) + (30'(r_sd[ST_S].r) << 3);
        ovr_n = (30'(r_s) >= r40);

        sum_x2 = 76'(r_sq_ll) + (76'(r_sq_lh) << 33) + (76'(r_sq_hh) << 64)
               + 76'(32'h8000_0000);
        sum_x3 = 81'(r_p00) + ((81'(r_p01) + 81'(r_p10)) << 32) + (81'(r_p11) << 64)
               + 81'(32'h8000_0000);
        sum_g  = 96'(r_q_ll) + (96'(r_q_lh) << 33) + (96'(r_q_hh) << 64)
               + 96'(32'h8000_0000);
        sum_g2 = 128'(r_h_ll) + (128'(r_h_lh) << 33) + (128'(r_h_hh) << 64)
               + 128'(32'h8000_0000);

        // signed differences as magnitude and sign
        neg_n[0] = r_g2c < 96'(r_gc);
        abs_a    = neg_n[0] ? 96'(r_gc) - r_g2c : r_g2c - 96'(r_gc);
        neg_n[1] = r_t12 < 100'(r_t6);
        abs_b    = neg_n[1] ? 100'(r_t6) - r_t12 : r_t12 - 100'(r_t6);
        neg_n[2] = r_t156 < 104'(r_t42);
        abs_c    = neg_n[2] ? 104'(r_t42) - r_t156 : r_t156 - 104'(r_t42);

        // magnitudes this large saturate for any nonzero energy scale
        clamp_n[0] = |r_a[95:78];
        clamp_n[1] = |r_b[99:86];
        clamp_n[2] = |r_c[103:94];

        sum_e = ((104'(r_ea0) + (104'(r_ea1) << 32) + (104'(r_ea2) << 64)) << 2)
              + 104'(32'h8000_0000);
        sum_f = ((112'(r_eb0) + (112'(r_eb1) << 32) + (112'(r_eb2) << 64)) << 2)
              + (112'(r_sd[ST_EPP].r) << 15);
        sum_s = ((121'(r_ec0) + (121'(r_ec1) << 32) + (121'(r_ec2) << 64)) << 2)
              + 121'(r_sd[ST_EPP].rsq >> 1);

        lim_e = r_sd[ST_SUM].neg[0] ? NEG_MAG : POS_MAX;
        sat_e = r_sd[ST_SUM].sat[0] || (r_me > 72'(lim_e));
        ovf_f = (r_mf[95:48] >= 48'(r_sd[ST_SUM].r));
        ovf_s = (r_ms[120:48] >= 73'(r_sd[ST_SUM].rsq));

        // side band entries that pick up fields on their way in
        sd_xd0      = r_sd[ST_S];
        sd_xd0.ovr  = ovr_n;
        sd_abs      = r_sd[ST_MUL];
        sd_abs.neg  = neg_n;
        sd_epp      = r_sd[ST_ABS];
        sd_epp.sat  = clamp_n;
        sd_div0     = r_sd[ST_SUM];
        sd_div0.sat = {r_sd[ST_SUM].sat[2] | ovf_s, r_sd[ST_SUM].sat[1] | ovf_f, sat_e};
        sd_div0.em  = sat_e ? lim_e : r_me[47:0];
    end

    // Side band line, with fields filled in at their stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sd[0] <= sd_in;
            for (int i = 1; i <= ST_Q; i++) begin
                if (i == ST_XD0) begin
                    r_sd[i] <= sd_xd0;
                end else if (i == ST_ABS) begin
                    r_sd[i] <= sd_abs;
                end else if (i == ST_EPP) begin
                    r_sd[i] <= sd_epp;
                end else if (i == ST_DIV0) begin
                    r_sd[i] <= sd_div0;
                end else begin
                    r_sd[i] <= r_sd[i-1];
                end
            end
        end
    end

    // Payload stages outside the divider chains
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod <= 41'(r_length_scale) * 41'(scale_a);
            r_s    <= 25'((r_prod + 41'd32768) >> 16);

            // ratio divider: remainder from the top, numerator bits below
            r_xrem[0] <= 24'(r_s[24:6]);
            r_xw[0]   <= {r_s[5:0], 9'd0, r_sd[ST_S].r[23:1]};

            // x squared
            r_sq_ll <= 64'(r_xw[XBITS][31:0]) * 64'(r_xw[XBITS][31:0]);
            r_sq_lh <= 38'(r_xw[XBITS][31:0]) * 38'(r_xw[XBITS][37:32]);
            r_sq_hh <= 12'(r_xw[XBITS][37:32]) * 12'(r_xw[XBITS][37:32]);
            r_xa    <= r_xw[XBITS];
            r_x2    <= sum_x2[74:32];
            r_xb    <= r_xa;

            // x cubed
            r_p00 <= 64'(r_x2[31:0]) * 64'(r_xb[31:0]);
            r_p01 <= 38'(r_x2[31:0]) * 38'(r_xb[37:32]);
            r_p10 <= 43'(r_x2[42:32]) * 43'(r_xb[31:0]);
            r_p11 <= 17'(r_x2[42:32]) * 17'(r_xb[37:32]);
            r_x3  <= sum_x3[79:32];

            // sixth power
            r_q_ll <= 64'(r_x3[31:0]) * 64'(r_x3[31:0]);
            r_q_lh <= 48'(r_x3[31:0]) * 48'(r_x3[47:32]);
            r_q_hh <= 32'(r_x3[47:32]) * 32'(r_x3[47:32]);
            r_g    <= sum_g[95:32];

            // twelfth power
            r_h_ll <= 64'(r_g[31:0]) * 64'(r_g[31:0]);
            r_h_lh <= 64'(r_g[31:0]) * 64'(r_g[63:32]);
            r_h_hh <= 64'(r_g[63:32]) * 64'(r_g[63:32]);
            r_ga   <= r_g;
            r_g2   <= sum_g2[127:32];
            r_gb   <= r_ga;

            // constant weights
            r_t12  <= (100'(r_g2) << 3) + (100'(r_g2) << 2);
            r_t6   <= (67'(r_gb) << 2) + (67'(r_gb) << 1);
            r_t156 <= (104'(r_g2) << 7) + (104'(r_g2) << 4) + (104'(r_g2) << 3)
                    + (104'(r_g2) << 2);
            r_t42  <= (70'(r_gb) << 5) + (70'(r_gb) << 3) + (70'(r_gb) << 1);
            r_g2c  <= r_g2;
            r_gc   <= r_gb;

            r_a <= abs_a;
            r_b <= abs_b;
            r_c <= abs_c;

            // energy scale partial products
            r_ea0 <= 56'(r_energy_scale) * 56'(r_a[31:0]);
            r_ea1 <= 56'(r_energy_scale) * 56'(r_a[63:32]);
            r_ea2 <= 38'(r_energy_scale) * 38'(r_a[77:64]);
            r_eb0 <= 56'(r_energy_scale) * 56'(r_b[31:0]);
            r_eb1 <= 56'(r_energy_scale) * 56'(r_b[63:32]);
            r_eb2 <= 46'(r_energy_scale) * 46'(r_b[85:64]);
            r_ec0 <= 56'(r_energy_scale) * 56'(r_c[31:0]);
            r_ec1 <= 56'(r_energy_scale) * 56'(r_c[63:32]);
            r_ec2 <= 54'(r_energy_scale) * 54'(r_c[93:64]);

            r_me <= sum_e[103:32];
            r_mf <= sum_f[111:16];
            r_ms <= sum_s;

            // force and stiffness dividers
            r_frem[0] <= r_mf[71:48];
            r_fw[0]   <= r_mf[47:0];
            r_srem[0] <= r_ms[95:48];
            r_sw[0]   <= r_ms[47:0];
        end
    end

    // Ratio divider, one quotient bit per stage
    for (genvar k = 0; k < XBITS; k++) begin : g_xdiv
        logic [24:0] trial;
        logic [24:0] dvs;
        logic        ge;
        assign dvs   = {1'b0, r_sd[ST_XD0+k].r};
        assign trial = {r_xrem[k], r_xw[k][XBITS-1]};
        assign ge    = (trial >= dvs);
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_xrem[k+1] <= ge ? 24'(trial - dvs) : trial[23:0];
                r_xw[k+1]   <= {r_xw[k][XBITS-2:0], ge};
            end
        end
    end

    // Force (by r) and stiffness (by r squared) dividers
    for (genvar k = 0; k < QBITS; k++) begin : g_qdiv
        logic [24:0] ftrial, fdvs;
        logic [48:0] strial, sdvs;
        logic        fge, sge;
        assign fdvs   = {1'b0, r_sd[ST_DIV0+k].r};
        assign ftrial = {r_frem[k], r_fw[k][QBITS-1]};
        assign fge    = (ftrial >= fdvs);
        assign sdvs   = {1'b0, r_sd[ST_DIV0+k].rsq};
        assign strial = {r_srem[k], r_sw[k][QBITS-1]};
        assign sge    = (strial >= sdvs);
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_frem[k+1] <= fge ? 24'(ftrial - fdvs) : ftrial[23:0];
                r_fw[k+1]   <= {r_fw[k][QBITS-2:0], fge};
                r_srem[k+1] <= sge ? 48'(strial - sdvs) : strial[47:0];
                r_sw[k+1]   <= {r_sw[k][QBITS-2:0], sge};
            end
        end
    end

    // Apply signs, saturation and the special cases
    always_comb begin
        sdq   = r_sd[ST_Q];
        neg_f = !sdq.neg[1] && (sdq.sat[1] || (r_fw[QBITS] != 48'd0));
        lim_f = neg_f ? NEG_MAG : POS_MAX;
        sat_f = sdq.sat[1] || (r_fw[QBITS] > lim_f);
        mag_f = sat_f ? lim_f : r_fw[QBITS];
        lim_s = sdq.neg[2] ? NEG_MAG : POS_MAX;
        sat_s = sdq.sat[2] || (r_sw[QBITS] > lim_s);
        mag_s = sat_s ? lim_s : r_sw[QBITS];

        if (sdq.zero) begin
            n_energy = '0;
            n_force  = '0;
            n_stiff  = '0;
            n_status = STAT_ZERO;
        end else if (r_energy_scale == 24'd0) begin
            n_energy = '0;
            n_force  = '0;
            n_stiff  = '0;
            n_status = STAT_OK;
        end else if (sdq.ovr) begin
            n_energy = POS_MAX;
            n_force  = NEG_MAG;
            n_stiff  = POS_MAX;
            n_status = STAT_SAT;
        end else begin
            n_energy = sdq.neg[0] ? 48'd0 - sdq.em : sdq.em;
            n_force  = neg_f ? 48'd0 - mag_f : mag_f;
            n_stiff  = sdq.neg[2] ? 48'd0 - mag_s : mag_s;
            n_status = (sdq.sat[0] || sat_f || sat_s) ? STAT_SAT : STAT_OK;
        end
    end

    // Output register, held while the transfer is stalled
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_energy <= n_energy;
            r_force  <= n_force;
            r_stiff  <= n_stiff;
            r_status <= n_status;
        end
    end

    assign o_energy    = r_energy;
    assign o_force_res = r_force;
    assign o_stiffness = r_stiff;
    assign o_status    = r_status;

endmodule

[sim/tb.sv]
// Self-checking testbench for lennard_jones_force_pipeline.
// Depends on ljfp_pkg and the pipeline RTL; a built-in fixed-point predictor
// supplies the expected energy, force, stiffness and status of every transfer.
module tb;
    import ljfp_pkg::*;

    localparam int LATENCY   = ST_OUT + 1;
    localparam int LIMIT     = 400000;
    localparam int LONG_HOLD = 300;

    typedef struct {
        logic [47:0] energy;
        logic [47:0] force_res;
        logic [47:0] stiffness;
        logic [1:0]  status;
    } t_lj_result;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [1:0]         i_cfg_idx = '0;
    logic [23:0]        i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [23:0]        i_distance = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [47:0] o_energy;
    logic signed [47:0] o_force_res;
    logic signed [47:0] o_stiffness;
    logic [1:0]         o_status;

    // Mirror of the configuration registers
    logic [23:0] cur_length = 24'd65536;
    logic [23:0] cur_energy = 24'd65536;
    logic [15:0] cur_elong  = 16'd0;

    t_lj_result pending_results[$];
    int  error_count = 0;
    int  cycle_count = 0;
    bit  no_idle = 1'b0;
    int  hold_token = 0;
    int  hold_seen = 0;
    int  hold_left = 0;
    int  stall_left = 0;

    lennard_jones_force_pipeline u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_distance  (i_distance),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_energy    (o_energy),
        .o_force_res (o_force_res),
        .o_stiffness (o_stiffness),
        .o_status    (o_status)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // round(a*b / 2^32)
    function automatic logic [63:0] mul_q32(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = 128'(a) * 128'(b) + 128'(64'h8000_0000);
        return p[95:32];
    endfunction

    function automatic logic [127:0] abs_diff(input logic [127:0] a, input logic [127:0] b,
                                              output logic neg);
        neg = (a < b);
        return neg ? (b - a) : (a - b);
    endfunction

    // round(mag * e4 / d), flag anything beyond 128 bits
    function automatic logic [127:0] scale_div(input logic [127:0] mag, input logic [63:0] e4,
                                               input logic [63:0] d, inout logic ovf);
        logic [159:0] prod;
        logic [128:0] num;
        prod = 160'(mag) * 160'(e4);
        if (prod[159:128] != 0) ovf = 1'b1;
        num = 129'(prod[127:0]) + 129'(d >> 1);
        if (num[128]) ovf = 1'b1;
        return num[127:0] / 128'(d);
    endfunction

    function automatic logic [47:0] clamp_out(input logic [127:0] mag, input logic neg,
                                              input logic ovf, inout logic sat);
        logic [127:0] lim;
        lim = neg ? 128'(NEG_MAG) : 128'(POS_MAX);
        if (ovf || mag > lim) begin
            sat = 1'b1;
            mag = lim;
        end
        return neg ? (48'd0 - mag[47:0]) : mag[47:0];
    endfunction

    function automatic t_lj_result predict_pair(input logic [23:0] r);
        logic [63:0]  a_fac, s, x, g, e4;
        logic [127:0] g2, mag, t1, t2;
        logic         neg, ovf, sat;
        t_lj_result   res;
        res.energy = '0;
        res.force_res = '0;
        res.stiffness = '0;
        res.status = STAT_OK;
        sat = 1'b0;
        if (r == 0) begin
            res.status = STAT_ZERO;
            return res;
        end
        if (cur_energy == 0) return res;

        a_fac = 64'd65536 + {{48{cur_elong[15]}}, cur_elong};
        s = (64'(cur_length) * a_fac + 64'd32768) >> 16;
        x = ((s << 32) + 64'(r >> 1)) / 64'(r);
        // ratio too large: every value is out of range
        if (x >= (64'd40 << 32)) begin
            res.energy = POS_MAX;
            res.force_res = NEG_MAG;
            res.stiffness = POS_MAX;
            res.status = STAT_SAT;
            return res;
        end
        g = mul_q32(x, x);
        g = mul_q32(g, x);
        g = mul_q32(g, g);
        t1 = 128'(g) * 128'(g) + 128'(64'h8000_0000);
        g2 = t1 >> 32;
        e4 = 64'(cur_energy) * 64'd4;

        // energy
        ovf = 1'b0;
        mag = abs_diff(g2, 128'(g), neg);
        mag = scale_div(mag, e4, 64'd1 << 32, ovf);
        res.energy = clamp_out(mag, neg, ovf, sat);

        // force, sign flipped
        ovf = 1'b0;
        t1 = g2 * 128'd12;
        t2 = 128'(g) * 128'd6;
        mag = abs_diff(t1, t2, neg);
        mag = scale_div(mag, e4, 64'(r) << 16, ovf);
        res.force_res = clamp_out(mag, !neg && mag != 0, ovf, sat);

        // stiffness
        ovf = 1'b0;
        t1 = g2 * 128'd156;
        t2 = 128'(g) * 128'd42;
        mag = abs_diff(t1, t2, neg);
        mag = scale_div(mag, e4, 64'(r) * 64'(r), ovf);
        res.stiffness = clamp_out(mag, neg, ovf, sat);

        res.status = sat ? STAT_SAT : STAT_OK;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result side: stall generation and checking
    // ------------------------------------------------------------------

    // Draw a stall after each transfer; honor long hold requests
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= LONG_HOLD - 1;
            i_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else if (o_valid && !i_stall && !no_idle) begin
            int n;
            n = $urandom_range(0, 4);
            i_stall <= (n > 0);
            stall_left <= (n > 0) ? n - 1 : 0;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            t_lj_result want;
            if (pending_results.size() == 0) begin
                $error("unexpected result: energy %h", o_energy);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_energy !== want.energy) begin
                    $error("energy: expected %h, actual %h", want.energy, o_energy);
                    error_count++;
                end
                if (o_force_res !== want.force_res) begin
                    $error("force_res: expected %h, actual %h", want.force_res, o_force_res);
                    error_count++;
                end
                if (o_stiffness !== want.stiffness) begin
                    $error("stiffness: expected %h, actual %h", want.stiffness, o_stiffness);
                    error_count++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_status);
                    error_count++;
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one distance and hold it until the transfer
    task automatic send_distance(input logic [23:0] d);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_distance <= d;
        do @(posedge i_clk); while (o_stall);
        pending_results.push_back(predict_pair(d));
    endtask

    // Stop offering and wait until every result is back
    task automatic drain;
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [23:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_LENGTH_SCALE: cur_length = data;
            CFG_ENERGY_SCALE: cur_energy = data;
            default:          cur_elong = data[15:0];
        endcase
    endtask

    task automatic set_config(input logic [23:0] ls, input logic [23:0] es,
                              input logic [15:0] el);
        drain();
        write_reg(CFG_LENGTH_SCALE, ls);
        write_reg(CFG_ENERGY_SCALE, es);
        write_reg(CFG_ELONGATION, {8'd0, el});
    endtask

    // Mostly distances near the length scale, some anywhere
    function automatic logic [23:0] pick_distance;
        logic [23:0] base;
        int sel;
        sel = $urandom_range(0, 9);
        base = (cur_length < 24'd256) ? 24'd256 : cur_length;
        if (sel < 6)
            return 24'($urandom_range(base / 2, (base > 24'h3FFFFF) ? 24'hFFFFFF : base * 3));
        else if (sel < 9)
            return 24'($urandom);
        else
            return 24'($urandom_range(0, 4));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes and named corner cases at reset settings
    task automatic test_directed;
        logic [23:0] pts[$];
        pts = '{24'd0, 24'd1, 24'hFFFFFF, 24'h010000, 24'h011F5A, 24'h008000,
                24'h000400, 24'd1638, 24'd1639, 24'h020000, 24'h030000,
                24'h800000, 24'h7FFFFF, 24'h00FFFF, 24'h555555, 24'hAAAAAA};
        foreach (pts[k]) send_distance(pts[k]);
        // zero energy scale gives all-zero results
        set_config(24'h010000, 24'd0, 16'd0);
        send_distance(24'h010000);
        send_distance(24'd0);
        send_distance(24'd5);
    endtask

    // Register extremes, each with a short burst
    task automatic test_config_extremes;
        logic [23:0] ls_set[6];
        logic [23:0] es_set[6];
        logic [15:0] el_set[6];
        ls_set = '{24'hFFFFFF, 24'd0, 24'h010000, 24'h010000, 24'h000001, 24'h020000};
        es_set = '{24'h010000, 24'h010000, 24'hFFFFFF, 24'h000001, 24'hFFFFFF, 24'h008000};
        el_set = '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h0000, 16'hF000};
        for (int c = 0; c < 6; c++) begin
            set_config(ls_set[c], es_set[c], el_set[c]);
            send_distance(24'd0);
            send_distance(24'hFFFFFF);
            send_distance(ls_set[c]);
            for (int k = 0; k < 40; k++) send_distance(pick_distance());
        end
    endtask

    // Random settings and distances, with stretches of full rate
    task automatic test_random;
        for (int phase = 0; phase < 10; phase++) begin
            set_config(24'($urandom_range(24'h004000, 24'h040000)),
                       24'($urandom_range(0, 24'hFFFFFF)),
                       16'($urandom));
            no_idle = (phase % 3 == 1);
            for (int k = 0; k < 35; k++) send_distance(pick_distance());
            no_idle = 1'b0;
        end
    endtask

    // Long receiver hold while the sender keeps offering at full rate
    task automatic test_backpressure;
        set_config(24'h010000, 24'h010000, 16'h0100);
        no_idle = 1'b1;
        hold_token++;
        for (int k = 0; k < 150; k++) send_distance(pick_distance());
        no_idle = 1'b0;
    endtask

    // Sender pauses until everything is back, then resumes
    task automatic test_pause;
        for (int k = 0; k < 30; k++) send_distance(pick_distance());
        drain();
        for (int k = 0; k < 30; k++) send_distance(pick_distance());
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_extremes();
        test_random();
        test_backpressure();
        test_pause();
        drain();
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
